FILE: rtl/core/oaht_pkg.sv
`timescale 1ns / 1ps
package oaht_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        ACT_SET = 2'd0,
        ACT_GET = 2'd1,
        ACT_DEL = 2'd2,
        ACT_NOP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_BYTES,
        H_QUOT,
        H_PROD,
        H_MOD
    } hash_state_t;

    // one table slot as stored in the slot memory
    typedef struct packed {
        logic        occupied;
        logic        tombstone;
        logic [3:0]  key_len;
        logic [63:0] key;
        logic [63:0] value;
    } entry_t;

    // request from the controller to the hash unit
    typedef struct packed {
        logic        start;
        logic [3:0]  len;
        logic [63:0] key;
    } hash_req_t;

    // keeps only the first len bytes
    function automatic logic [63:0] key_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
            begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/open_address_hash_table.sv
`timescale 1ns / 1ps
// Open-addressed key/value table of CAPACITY slots with linear probing and
// tombstones. Each transfer on the input channel is a set, get, delete or no-op
// of a key of up to KEY_BYTES bytes and gives exactly one result transfer. Keys
// are hashed with 32-bit FNV-1a one byte per cycle, then reduced modulo
// CAPACITY by a reciprocal multiply, a back multiply and one correcting
// subtract. Every probe is a read of the single slot memory followed by a
// compare, and a request ends with a write state; requests that fail early
// (load limit, empty table, unknown action) go straight to the result. One
// request is in flight at a time; a finished result waits in the output
// register while the next request is taken. After reset the block clears
// every slot of the slot memory with in_stall held high. A set that would
// push the slot count past three quarters of CAPACITY is refused with
// status 1, which keeps probing from running through the whole table.
module open_address_hash_table #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_length,
    input  logic [63:0] value_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [63:0] value_out,
    output logic        status
);
    import oaht_pkg::*;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int MAX_USED = (3 * CAPACITY) / 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] USED_LIM = IDX_W'(MAX_USED);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [3:0]       KEY_MAX  = 4'(KEY_BYTES);

    ctrl_state_t      state_reg, state_next;

    // request being served
    logic [1:0]       action_reg, action_next;
    logic [63:0]      key_reg, key_next;
    logic [3:0]       len_reg, len_next;
    logic [63:0]      val_reg, val_next;

    // probe walk
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] tomb_idx_reg, tomb_idx_next;
    logic             tomb_vld_reg, tomb_vld_next;

    // probe outcome
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             slot_vld_reg, slot_vld_next;
    logic             slot_tomb_reg, slot_tomb_next;
    logic             hit_reg, hit_next;
    logic [63:0]      hitval_reg, hitval_next;

    // table bookkeeping, tombstones included
    logic [IDX_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    // result waiting for the output register
    logic             res_success_reg, res_success_next;
    logic             res_status_reg, res_status_next;
    logic [63:0]      res_value_reg, res_value_next;

    logic             out_valid_reg, out_valid_next;
    logic             success_reg, success_next;
    logic             status_reg, status_next;
    logic [63:0]      value_out_reg, value_out_next;

    // memory and hash unit hookup
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    entry_t           mem_rdata;
    hash_req_t        hreq;
    logic             h_done;
    logic [IDX_W-1:0] h_index;

    logic [3:0]       len_c;
    logic [63:0]      key_c;

    oaht_slot_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    oaht_hash #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .done  (h_done),
        .index (h_index)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        key_reg         <= key_next;
        len_reg         <= len_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        n_reg           <= n_next;
        tomb_idx_reg    <= tomb_idx_next;
        tomb_vld_reg    <= tomb_vld_next;
        slot_reg        <= slot_next;
        slot_vld_reg    <= slot_vld_next;
        slot_tomb_reg   <= slot_tomb_next;
        hit_reg         <= hit_next;
        hitval_reg      <= hitval_next;
        res_success_reg <= res_success_next;
        res_status_reg  <= res_status_next;
        res_value_reg   <= res_value_next;
        success_reg     <= success_next;
        status_reg      <= status_next;
        value_out_reg   <= value_out_next;
    end

    // long keys clamp to KEY_BYTES, unused bytes dropped
    assign len_c = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    assign key_c = key_bytes & key_mask(len_c);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    always_comb
    begin
        logic             match;
        logic             tv;
        logic [IDX_W-1:0] ti;

        state_next       = state_reg;
        action_next      = action_reg;
        key_next         = key_reg;
        len_next         = len_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        tomb_idx_next    = tomb_idx_reg;
        tomb_vld_next    = tomb_vld_reg;
        slot_next        = slot_reg;
        slot_vld_next    = slot_vld_reg;
        slot_tomb_next   = slot_tomb_reg;
        hit_next         = hit_reg;
        hitval_next      = hitval_reg;
        used_next        = used_reg;
        clr_next         = clr_reg;
        res_success_next = res_success_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        success_next     = success_reg;
        status_next      = status_reg;
        value_out_next   = value_out_reg;
        out_valid_next   = out_valid_reg;
        mem_we           = 1'b0;
        mem_waddr        = slot_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        hreq             = '0;

        match = mem_rdata.occupied && (mem_rdata.key_len == len_reg)
                && (mem_rdata.key == key_reg);
        tv    = tomb_vld_reg;
        ti    = tomb_idx_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // clearing pass: one slot per cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_ONE;
                if (clr_reg == LAST_IDX)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next      = action;
                    key_next         = key_c;
                    len_next         = len_c;
                    val_next         = value_in;
                    res_success_next = 1'b0;
                    res_status_next  = 1'b0;
                    res_value_next   = '0;
                    hreq.key         = key_c;
                    hreq.len         = len_c;
                    case (action_t'(action))
                        ACT_SET:
                        begin
                            if (used_reg >= USED_LIM)
                            begin
                                // load limit: refused, table untouched
                                res_status_next = 1'b1;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                hreq.start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        ACT_GET, ACT_DEL:
                        begin
                            if (used_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                hreq.start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (h_done)
                begin
                    idx_next      = h_index;
                    n_next        = '0;
                    tomb_vld_next = 1'b0;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (match)
                begin
                    hit_next       = 1'b1;
                    slot_vld_next  = 1'b1;
                    slot_next      = idx_reg;
                    slot_tomb_next = 1'b0;
                    hitval_next    = mem_rdata.value;
                    state_next     = S_WRITE;
                end
                else if (!mem_rdata.occupied && !mem_rdata.tombstone)
                begin
                    // empty slot ends the walk; first tombstone wins
                    hit_next       = 1'b0;
                    slot_vld_next  = 1'b1;
                    slot_next      = tomb_vld_reg ? tomb_idx_reg : idx_reg;
                    slot_tomb_next = tomb_vld_reg;
                    state_next     = S_WRITE;
                end
                else
                begin
                    if (!mem_rdata.occupied && !tomb_vld_reg)
                    begin
                        tv = 1'b1;
                        ti = idx_reg;
                    end
                    tomb_vld_next = tv;
                    tomb_idx_next = ti;
                    if (n_reg == LAST_IDX)
                    begin
                        // walked every slot
                        hit_next       = 1'b0;
                        slot_vld_next  = tv;
                        slot_next      = ti;
                        slot_tomb_next = 1'b1;
                        state_next     = S_WRITE;
                    end
                    else
                    begin
                        idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_ONE;
                        n_next     = n_reg + IDX_ONE;
                        state_next = S_READ;
                    end
                end
            end
            S_WRITE:
            begin
                case (action_t'(action_reg))
                    ACT_SET:
                    begin
                        if (slot_vld_reg)
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = slot_reg;
                            mem_wdata.occupied  = 1'b1;
                            mem_wdata.tombstone = 1'b0;
                            mem_wdata.key_len   = len_reg;
                            mem_wdata.key       = key_reg;
                            mem_wdata.value     = val_reg;
                            res_success_next    = !hit_reg;
                            if (!hit_reg && !slot_tomb_reg)
                            begin
                                used_next = used_reg + IDX_ONE;
                            end
                        end
                    end
                    ACT_GET:
                    begin
                        if (hit_reg)
                        begin
                            res_success_next = 1'b1;
                            res_value_next   = hitval_reg;
                        end
                    end
                    ACT_DEL:
                    begin
                        if (hit_reg)
                        begin
                            // leave a tombstone, slot stays counted
                            mem_we              = 1'b1;
                            mem_waddr           = slot_reg;
                            mem_wdata.occupied  = 1'b0;
                            mem_wdata.tombstone = 1'b1;
                            mem_wdata.key_len   = len_reg;
                            mem_wdata.key       = key_reg;
                            mem_wdata.value     = hitval_reg;
                            res_success_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_success_next = 1'b0;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    success_next   = res_success_reg;
                    status_next    = res_status_reg;
                    value_out_next = res_value_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/oaht_slot_ram.sv
`timescale 1ns / 1ps
module oaht_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  oaht_pkg::entry_t     wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output oaht_pkg::entry_t     rdata
);
    import oaht_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, updated only when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/oaht_hash.sv
`timescale 1ns / 1ps
module oaht_hash #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oaht_pkg::hash_req_t req,
    output logic                done,
    output logic [IDX_W-1:0]    index
);
    import oaht_pkg::*;

    localparam logic [31:0] CAP32 = 32'(CAPACITY);
    // floor(2^32 / CAPACITY): the quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));

    hash_state_t      state_reg, state_next;
    logic [31:0]      h_reg, h_next;
    logic [63:0]      key_sh_reg, key_sh_next;
    logic [3:0]       len_reg, len_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [31:0]      q_reg, q_next;
    logic [31:0]      qc_reg, qc_next;
    logic [63:0]      prod;
    logic [31:0]      r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        key_sh_reg <= key_sh_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        q_reg      <= q_next;
        qc_reg     <= qc_next;
    end

    // reciprocal quotient, then remainder with one correcting subtract
    always_comb
    begin
        prod = 64'(h_reg) * 64'(RECIP);
        r    = h_reg - qc_reg;
        if (r >= CAP32)
        begin
            r = r - CAP32;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        h_next      = h_reg;
        key_sh_next = key_sh_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        qc_next     = qc_reg;
        done        = 1'b0;
        index       = r[IDX_W-1:0];
        case (state_reg)
            H_IDLE:
            begin
                if (req.start)
                begin
                    h_next      = FNV_BASIS;
                    key_sh_next = req.key;
                    len_next    = req.len;
                    cnt_next    = '0;
                    state_next  = H_BYTES;
                end
            end
            H_BYTES:
            begin
                if (cnt_reg == len_reg)
                begin
                    state_next = H_QUOT;
                end
                else
                begin
                    // one byte per cycle, multiplier registered
                    h_next      = 32'((h_reg ^ {24'd0, key_sh_reg[7:0]}) * FNV_PRIME);
                    key_sh_next = key_sh_reg >> 8;
                    cnt_next    = cnt_reg + 4'd1;
                end
            end
            H_QUOT:
            begin
                q_next     = prod[63:32];
                state_next = H_PROD;
            end
            H_PROD:
            begin
                qc_next    = q_reg * CAP32;
                state_next = H_MOD;
            end
            H_MOD:
            begin
                done       = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/oaht_checker.sv
`timescale 1ns / 1ps
module oaht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        success,
    input logic [63:0] value_out,
    input logic        status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(success)
            && $stable(status) && $stable(value_out))
        else $error("result changed while stalled");

    // a refused set never reports success
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !success && (value_out == 64'd0))
        else $error("refused set reported success or value");

    // a nonzero value only comes with a successful, unrefused result
    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (value_out != 64'd0) |-> success && !status)
        else $error("value on a result that is not a successful get");

    // one request at a time: a transfer in closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is in flight");

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (.*);

FILE: verif/open_address_hash_table_tb.sv
`timescale 1ns / 1ps
module open_address_hash_table_tb;

    import oaht_pkg::*;

    localparam int SLOTS        = 64;
    localparam int KEY_W        = 8;
    localparam int POOL_KEYS    = 64;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 300;
    localparam int STUCK_LIMIT  = 5000;

    // one request as presented on the input channel
    typedef struct {
        action_t     act;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } request_t;

    // one answer as seen on the output channel
    typedef struct packed {
        logic        success;
        logic [63:0] value;
        logic        status;
    } reply_t;

    // receiver behavior, switched now and then at random
    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_SET;
    logic [63:0] key_bytes = '0;
    logic [3:0]  key_length = '0;
    logic [63:0] value_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        success;
    logic [63:0] value_out;
    logic        status;

    // requests waiting to be sent, answers waiting to come back
    request_t pending[$];
    reply_t   replies[$];

    // shadow copy of the slot table
    logic [63:0] tab_key [SLOTS];
    logic [3:0]  tab_len [SLOTS];
    logic [63:0] tab_val [SLOTS];
    bit          tab_live [SLOTS];
    bit          tab_tomb [SLOTS];
    int          tab_count = 0;

    // key pool for the random part
    logic [63:0] pool_key [POOL_KEYS];
    logic [3:0]  pool_len [POOL_KEYS];

    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    // sender and receiver pacing
    int          burst_left = 8;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 100;
    int          hold_left = 0;

    open_address_hash_table #(
        .CAPACITY  (SLOTS),
        .KEY_BYTES (KEY_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .value_in   (value_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .success    (success),
        .value_out  (value_out),
        .status     (status)
    );

    always #10 clk = ~clk;

    // low n bytes set, n of 8 or more keeps everything
    function automatic logic [63:0] byte_mask(logic [3:0] n);
        return (n >= 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // slot holding the key, else the slot an insert would take, else -1
    function automatic int find_slot(logic [63:0] k, logic [3:0] n);
        logic [31:0] h;
        int          idx;
        int          tomb;
        h = FNV_BASIS;
        for (int i = 0; i < int'(n); i++)
        begin
            h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
        end
        idx  = int'(h % 32'(SLOTS));
        tomb = -1;
        for (int p = 0; p < SLOTS; p++)
        begin
            if (!tab_live[idx])
            begin
                // an empty slot ends the search, a tombstone only marks a reuse spot
                if (!tab_tomb[idx])
                begin
                    return (tomb >= 0) ? tomb : idx;
                end
                if (tomb < 0)
                begin
                    tomb = idx;
                end
            end
            else if (tab_len[idx] == n && tab_key[idx] == k)
            begin
                return idx;
            end
            idx = (idx + 1) % SLOTS;
        end
        return tomb;
    endfunction

    // applies one request to the shadow table and gives the answer it should get
    function automatic reply_t predict_reply(request_t rq);
        reply_t      rp;
        logic [3:0]  n;
        logic [63:0] k;
        int          s;
        rp = '0;
        n  = (rq.len > 4'(KEY_W)) ? 4'(KEY_W) : rq.len;
        k  = rq.key & byte_mask(n);
        case (rq.act)
            ACT_SET:
            begin
                // load limit counts tombstones and is checked before any lookup
                if (4 * (tab_count + 1) > 3 * SLOTS)
                begin
                    rp.status = 1'b1;
                end
                else
                begin
                    s = find_slot(k, n);
                    if (s >= 0)
                    begin
                        rp.success = !tab_live[s];
                        if (!tab_live[s] && !tab_tomb[s])
                        begin
                            tab_count++;
                        end
                        tab_key[s]  = k;
                        tab_len[s]  = n;
                        tab_val[s]  = rq.value;
                        tab_live[s] = 1'b1;
                        tab_tomb[s] = 1'b0;
                    end
                end
            end
            ACT_GET, ACT_DEL:
            begin
                if (tab_count != 0)
                begin
                    s = find_slot(k, n);
                    if (s >= 0 && tab_live[s])
                    begin
                        rp.success = 1'b1;
                        if (rq.act == ACT_GET)
                        begin
                            rp.value = tab_val[s];
                        end
                        else
                        begin
                            tab_live[s] = 1'b0;
                            tab_tomb[s] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return rp;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_request(action_t a, logic [63:0] k, logic [3:0] n, logic [63:0] v);
        request_t rq;
        rq.act   = a;
        rq.key   = k;
        rq.len   = n;
        rq.value = v;
        pending.push_back(rq);
    endtask

    // driver: presents queued requests in bursts with random gaps in between
    always @(posedge clk)
    begin
        bit presenting;
        if (rst_n)
        begin
            presenting = in_valid;
            if (in_valid && !in_stall)
            begin
                // transfer taken at this edge: predict it now
                replies.push_back(predict_reply(pending.pop_front()));
                presenting = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // mostly short bursts, now and then a long run with no idling
                    burst_left = ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(40, 120) : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!presenting)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending.size() > 0)
                begin
                    presenting = 1'b1;
                end
            end
            in_valid <= presenting;
            if (presenting)
            begin
                action     <= pending[0].act;
                key_bytes  <= pending[0].key;
                key_length <= pending[0].len;
                value_in   <= pending[0].value;
            end
        end
    end

    // monitor: checks each result transfer and drives the receiver stall
    always @(posedge clk)
    begin
        reply_t want;
        bit     nxt_stall;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end

            if (out_valid && !out_stall)
            begin
                if (replies.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = replies.pop_front();
                    if (success !== want.success)
                    begin
                        $error("success: expected %0d, actual %0d", want.success, success);
                        mismatches++;
                    end
                    if (value_out !== want.value)
                    begin
                        $error("value_out: expected %h, actual %h", want.value, value_out);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                end
            end

            // pick a new stall behavior now and then
            if (mode_left <= 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(50, 300);
            end
            else
            begin
                mode_left--;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_SPARSE:
                    begin
                        nxt_stall = ($urandom_range(0, 3) == 0);
                    end
                    STALL_LONG:
                    begin
                        nxt_stall = ($urandom_range(0, 7) == 0);
                        if (nxt_stall)
                        begin
                            hold_left = $urandom_range(1, 20);
                        end
                    end
                    default:
                    begin
                        nxt_stall = 1'b0;
                    end
                endcase
            end
            out_stall <= nxt_stall;
        end
    end

    initial
    begin
        int          active;
        int          pick;
        int          r;
        logic [3:0]  n;
        logic [63:0] m;
        action_t     a;

        // directed part: empty table first, then key edge cases
        add_request(ACT_GET, 64'h0123_4567_89ab_cdef, 4'd8, rand64());
        add_request(ACT_DEL, 64'h0123_4567_89ab_cdef, 4'd8, rand64());
        add_request(ACT_NOP, '1, 4'd15, '1);
        // empty key: no bytes hashed, every key bit ignored
        add_request(ACT_SET, '0, 4'd0, '1);
        add_request(ACT_GET, '1, 4'd0, '0);
        add_request(ACT_SET, '1, 4'd8, '0);
        add_request(ACT_SET, '0, 4'd8, 64'h5555_5555_5555_5555);
        // over-long length acts as a full 8-byte key
        add_request(ACT_SET, 64'h0123_4567_89ab_cdef, 4'd15, 64'haaaa_aaaa_aaaa_aaaa);
        add_request(ACT_GET, 64'h0123_4567_89ab_cdef, 4'd8, '0);
        // one-byte key, garbage above the valid byte
        add_request(ACT_SET, 64'hffff_ffff_ffff_ff5a, 4'd1, 64'd1);
        add_request(ACT_SET, 64'h0000_0000_0000_005a, 4'd1, 64'd2);
        add_request(ACT_GET, 64'h1234_5678_9abc_de5a, 4'd1, '1);
        add_request(ACT_GET, 64'h0000_0000_0000_005a, 4'd2, '0);
        // delete, miss on the tombstone, then reuse it
        add_request(ACT_DEL, 64'h0000_0000_0000_ab5a, 4'd1, '0);
        add_request(ACT_GET, 64'h0000_0000_0000_005a, 4'd1, '0);
        add_request(ACT_DEL, 64'h0000_0000_0000_005a, 4'd1, '0);
        add_request(ACT_SET, 64'h0000_0000_0000_005a, 4'd1, 64'd3);
        add_request(ACT_GET, 64'h0000_0000_0000_005a, 4'd1, '0);
        add_request(ACT_NOP, '0, 4'd0, '0);
        add_request(ACT_GET, '1, 4'd8, '0);
        add_request(ACT_DEL, '1, 4'd12, '0);
        add_request(ACT_GET, '1, 4'd8, '0);
        add_request(ACT_SET, 64'h8000_0000_0000_0000, 4'd8, 64'h8000_0000_0000_0001);

        // key pool, with some entries copying the bytes of the one before under their own random length
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_len[i] = 4'($urandom_range(0, 8));
            pool_key[i] = rand64();
            if (i > 0 && $urandom_range(0, 4) == 0)
            begin
                pool_key[i] = pool_key[i-1];
            end
        end

        // random part: the pool grows slowly so the table fills up over the run, until
        // sets hit the load limit; deletes leave tombstones all along
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            active = 10 + i / 30;
            if (active > POOL_KEYS)
            begin
                active = POOL_KEYS;
            end
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                add_request(ACT_NOP, rand64(), 4'($urandom), rand64());
            end
            else if (r < 12)
            begin
                // stray key, mostly lookups so it does not flood the table
                a = ($urandom_range(0, 4) == 0) ? ACT_SET : action_t'($urandom_range(1, 2));
                add_request(a, rand64(), 4'($urandom), rand64());
            end
            else
            begin
                pick = $urandom_range(0, active - 1);
                r    = $urandom_range(0, 99);
                a    = (r < 40) ? ACT_SET : ((r < 75) ? ACT_GET : ACT_DEL);
                n    = pool_len[pick];
                if (n == 4'd8 && $urandom_range(0, 3) == 0)
                begin
                    n = 4'($urandom_range(9, 15));
                end
                // random garbage above the valid bytes
                m = byte_mask(n);
                add_request(a, (pool_key[pick] & m) | (rand64() & ~m), n, rand64());
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            begin
                while (pending.size() != 0 || replies.size() != 0)
                begin
                    @(posedge clk);
                end
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                while (idle_cycles < STUCK_LIMIT)
                begin
                    @(posedge clk);
                end
                timed_out = 1'b1;
            end
        join_any

        if (timed_out || mismatches != 0)
        begin
            $display("end of test: mismatches");
        end
        else
        begin
            $display("end of test: clean");
        end
        $finish;
    end

endmodule
